// ===== rtl/tva_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tva_pkg
// Shared types, codes and helpers of the typed integer ALU pipeline.
// ----------------------------------------------------------------------------
package tva_pkg;

  localparam int unsigned XW = 64;
  localparam int unsigned NW = 32;
  localparam logic [XW-1:0] MASK32 = {{(XW-NW){1'b0}}, {NW{1'b1}}};

  typedef enum logic [4:0] {
    OP_ADD = 5'd0,  OP_SUB = 5'd1,  OP_MUL = 5'd2,  OP_DIV = 5'd3,
    OP_MOD = 5'd4,  OP_NOT = 5'd5,  OP_AND = 5'd6,  OP_OR  = 5'd7,
    OP_XOR = 5'd8,  OP_SHL = 5'd9,  OP_SHR = 5'd10, OP_SAR = 5'd11,
    OP_EQ  = 5'd12, OP_NE  = 5'd13, OP_LT  = 5'd14, OP_LE  = 5'd15,
    OP_GT  = 5'd16, OP_GE  = 5'd17
  } op_e;

  typedef enum logic [2:0] {
    TY_I32 = 3'd0, TY_UI32 = 3'd1, TY_I64 = 3'd2, TY_UI64 = 3'd3,
    TY_F32 = 3'd4, TY_F64 = 3'd5, TY_PTR = 3'd6
  } ty_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BAD_TYPE = 2'd1, ST_DIV_ZERO = 2'd2, ST_FLOAT = 2'd3
  } st_e;

  typedef struct packed {
    op_e           op;
    logic [2:0]    ta;
    logic [2:0]    rt;
    st_e           st;
    logic          narrow;
    logic          neg_q;
    logic          neg_r;
    logic [XW-1:0] rv;
  } meta_t;

  typedef struct packed {
    meta_t         meta;
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [XW-1:0] dx;
    logic [XW-1:0] dy;
  } dec_t;

  typedef struct packed {
    meta_t         meta;
    logic [XW-1:0] rem;
    logic [XW-1:0] quo;
    logic [XW-1:0] dvs;
  } div_t;

  function automatic logic is_narrow(logic [2:0] t);
    return (t == TY_I32) || (t == TY_UI32) || (t == TY_F32) || (t == TY_PTR);
  endfunction

  function automatic logic is_int(logic [2:0] t);
    return t <= TY_UI64;
  endfunction

  function automatic logic [XW-1:0] wmask(logic narrow);
    return narrow ? MASK32 : {XW{1'b1}};
  endfunction

  function automatic logic [XW-1:0] sext32(logic [XW-1:0] v);
    return {{(XW-NW){v[NW-1]}}, v[NW-1:0]};
  endfunction

endpackage

// ===== rtl/tva_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tva_decode
// Type table check, operand masking and divider operand preparation.
// ----------------------------------------------------------------------------
module tva_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [4:0]            op_i,
  input  logic [2:0]            ta_i,
  input  logic [tva_pkg::XW-1:0] a_i,
  input  logic [2:0]            tb_i,
  input  logic [tva_pkg::XW-1:0] b_i,
  output logic                  valid_o,
  output tva_pkg::dec_t         dec_o
);
  import tva_pkg::*;

  logic          valid_q;
  dec_t          dec_d, dec_q;
  logic          narrow, same_int, same_flt, sgn, sa, sb;
  logic [XW-1:0] m, x, y, sx, sy;
  logic [2:0]    rt;
  st_e           st;
  op_e           op;

  always_comb begin
    op       = op_e'(op_i);
    narrow   = is_narrow(ta_i);
    m        = wmask(narrow);
    x        = a_i & m;
    y        = b_i & m;
    same_int = (ta_i == tb_i) && is_int(ta_i);
    same_flt = (ta_i == tb_i) && ((ta_i == TY_F32) || (ta_i == TY_F64));
    rt       = 3'(TY_I32);
    st       = ST_OK;
    unique case (op)
      OP_ADD: begin
        if (same_int) rt = ta_i;
        else if ((ta_i <= TY_UI32 && tb_i == TY_PTR) ||
                 (ta_i == TY_PTR && tb_i <= TY_UI32)) rt = TY_PTR;
        else st = same_flt ? ST_FLOAT : ST_BAD_TYPE;
      end
      OP_SUB: begin
        if (same_int) rt = ta_i;
        else if (ta_i == TY_PTR && tb_i == TY_PTR) rt = TY_I64;
        else if (ta_i == TY_PTR && tb_i <= TY_UI32) rt = TY_PTR;
        else st = same_flt ? ST_FLOAT : ST_BAD_TYPE;
      end
      OP_MUL, OP_DIV, OP_MOD: begin
        if (same_int) begin
          rt = ta_i;
          if (op != OP_MUL && y == '0) st = ST_DIV_ZERO;
        end else st = same_flt ? ST_FLOAT : ST_BAD_TYPE;
      end
      OP_NOT: begin
        if (is_int(ta_i)) rt = ta_i;
        else st = ST_BAD_TYPE;
      end
      OP_AND, OP_OR, OP_XOR: begin
        if (same_int) rt = ta_i;
        else st = ST_BAD_TYPE;
      end
      OP_SHL, OP_SHR, OP_SAR: begin
        if (is_int(ta_i) && is_int(tb_i)) rt = ta_i;
        else st = ST_BAD_TYPE;
      end
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
        if (ta_i != tb_i || ta_i == 3'd7) st = ST_BAD_TYPE;
        else if (op >= OP_LT && (ta_i == TY_F32 || ta_i == TY_F64)) st = ST_FLOAT;
        else rt = TY_UI32;
      end
      default: st = ST_BAD_TYPE;
    endcase
    if (st != ST_OK) rt = 3'(TY_I32);

    // divider works on magnitudes; remember the signs to restore
    sgn = (ta_i == TY_I32) || (ta_i == TY_I64);
    sa  = narrow ? x[NW-1] : x[XW-1];
    sb  = narrow ? y[NW-1] : y[XW-1];
    sx  = narrow ? sext32(x) : x;
    sy  = narrow ? sext32(y) : y;

    dec_d.meta.op     = op;
    dec_d.meta.ta     = ta_i;
    dec_d.meta.rt     = rt;
    dec_d.meta.st     = st;
    dec_d.meta.narrow = narrow;
    dec_d.meta.neg_q  = sgn && (sa ^ sb);
    dec_d.meta.neg_r  = sgn && sa;
    dec_d.meta.rv     = '0;
    dec_d.x           = x;
    dec_d.y           = y;
    dec_d.dx          = (sgn && sa) ? ('0 - sx) : x;
    dec_d.dy          = (sgn && sb) ? ('0 - sy) : y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dec_q <= dec_d;
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

// ===== rtl/tva_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tva_exec
// Simple operations and a two-stage partial-product multiplier.
// ----------------------------------------------------------------------------
module tva_exec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tva_pkg::dec_t dec_i,
  output logic          valid_o,
  output tva_pkg::div_t div_o
);
  import tva_pkg::*;

  logic                 s2_valid_q, s3_valid_q;
  meta_t                s2_meta_d, s2_meta_q;
  logic [XW-1:0]        s2_dx_q, s2_dy_q;
  logic [XW-1:0]        p0_d, p0_q;
  logic [NW-1:0]        p1_d, p1_q, p2_d, p2_q;
  div_t                 s3_d, s3_q;
  logic [XW-1:0]        x, y, m, rm, cx, cy, sv, prod;
  logic signed [XW-1:0] sr;
  logic [5:0]           sh;
  logic                 eq, lt;

  always_comb begin
    x    = dec_i.x;
    y    = dec_i.y;
    m    = wmask(dec_i.meta.narrow);
    rm   = wmask(is_narrow(dec_i.meta.rt));
    sh   = y[5:0] & (dec_i.meta.narrow ? 6'd31 : 6'd63);
    // sign-extended operand for the arithmetic right shift
    sv   = (dec_i.meta.ta == TY_I32) ? sext32(x) : x;
    sr   = $signed(sv) >>> sh;
    cx   = (dec_i.meta.ta == TY_I32) ? sext32(x) : x;
    cy   = (dec_i.meta.ta == TY_I32) ? sext32(y) : y;
    if (dec_i.meta.ta == TY_I32 || dec_i.meta.ta == TY_I64) begin
      cx[XW-1] = ~cx[XW-1];
      cy[XW-1] = ~cy[XW-1];
    end
    eq   = (x == y);
    lt   = (cx < cy);
    s2_meta_d = dec_i.meta;
    unique case (dec_i.meta.op)
      OP_ADD:  s2_meta_d.rv = (x + y) & rm;
      OP_SUB:  s2_meta_d.rv = (x - y) & rm;
      OP_NOT:  s2_meta_d.rv = ~x & m;
      OP_AND:  s2_meta_d.rv = x & y;
      OP_OR:   s2_meta_d.rv = x | y;
      OP_XOR:  s2_meta_d.rv = x ^ y;
      OP_SHL:  s2_meta_d.rv = (x << sh) & m;
      OP_SHR:  s2_meta_d.rv = x >> sh;
      OP_SAR: begin
        if (dec_i.meta.ta == TY_UI32) s2_meta_d.rv = x >> sh;
        else s2_meta_d.rv = sr & m;
      end
      OP_EQ:   s2_meta_d.rv = XW'(eq);
      OP_NE:   s2_meta_d.rv = XW'(!eq);
      OP_LT:   s2_meta_d.rv = XW'(lt);
      OP_LE:   s2_meta_d.rv = XW'(lt || eq);
      OP_GT:   s2_meta_d.rv = XW'(!lt && !eq);
      OP_GE:   s2_meta_d.rv = XW'(!lt);
      default: s2_meta_d.rv = '0;
    endcase
    // low 64 bits of the product from three 32x32 partial products
    p0_d = {{(XW-NW){1'b0}}, x[NW-1:0]} * {{(XW-NW){1'b0}}, y[NW-1:0]};
    p1_d = NW'(x[NW-1:0] * y[XW-1:NW]);
    p2_d = NW'(x[XW-1:NW] * y[NW-1:0]);
  end

  always_comb begin
    prod = p0_q + {p1_q + p2_q, {NW{1'b0}}};
    s3_d.meta = s2_meta_q;
    if (s2_meta_q.op == OP_MUL) s3_d.meta.rv = prod & wmask(s2_meta_q.narrow);
    s3_d.rem = '0;
    s3_d.quo = s2_dx_q;
    s3_d.dvs = s2_dy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= valid_i;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_meta_q <= s2_meta_d;
      s2_dx_q   <= dec_i.dx;
      s2_dy_q   <= dec_i.dy;
      p0_q      <= p0_d;
      p1_q      <= p1_d;
      p2_q      <= p2_d;
      s3_q      <= s3_d;
    end
  end

  assign valid_o = s3_valid_q;
  assign div_o   = s3_q;

endmodule

// ===== rtl/tva_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tva_div_stage
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module tva_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tva_pkg::div_t div_i,
  output logic          valid_o,
  output tva_pkg::div_t div_o
);
  import tva_pkg::*;

  logic          valid_q;
  div_t          div_d, div_q;
  logic [XW:0]   trial, diff;
  logic          qbit;

  always_comb begin
    trial = {div_i.rem, div_i.quo[XW-1]};
    diff  = trial - {1'b0, div_i.dvs};
    qbit  = ~diff[XW];
    div_d      = div_i;
    div_d.rem  = qbit ? diff[XW-1:0] : trial[XW-1:0];
    div_d.quo  = {div_i.quo[XW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ===== rtl/tva_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tva_divider
// Pipelined unsigned divider, one stage per quotient bit.
// ----------------------------------------------------------------------------
module tva_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tva_pkg::div_t div_i,
  output logic          valid_o,
  output tva_pkg::div_t div_o
);
  import tva_pkg::*;

  logic [XW:0] vld;
  div_t        dat [XW+1];

  assign vld[0] = valid_i;
  assign dat[0] = div_i;

  for (genvar g = 0; g < XW; g++) begin : g_stage
    tva_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vld[g]),
      .div_i   (dat[g]),
      .valid_o (vld[g+1]),
      .div_o   (dat[g+1])
    );
  end

  assign valid_o = vld[XW];
  assign div_o   = dat[XW];

endmodule

// ===== rtl/typed_vm_integer_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_vm_integer_alu
// Typed integer ALU for a virtual machine: checks operand types, computes
// one tagged result word with a status code per input word.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | in_valid_i / in_ready_o    | operation, type_a, value_a,
//           |                            | type_b, value_b
//  output   | out_valid_o / out_ready_i  | result_type, result_value, status
//
// One word enters per cycle unless stalled. Stages: decode, two execute
// stages (simple ops, then the partial-product sum of the multiplier), 64
// divider stages (one quotient bit each) and the output register.
// Every word walks the full divider chain, which sets the latency.
// The whole pipeline advances together; it holds only while the output
// register is full and not taken, so a stall drops and repeats nothing.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module typed_vm_integer_alu (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [4:0]             operation_i,
  input  logic [2:0]             type_a_i,
  input  logic [tva_pkg::XW-1:0] value_a_i,
  input  logic [2:0]             type_b_i,
  input  logic [tva_pkg::XW-1:0] value_b_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             result_type_o,
  output logic [tva_pkg::XW-1:0] result_value_o,
  output logic [1:0]             status_o
);
  import tva_pkg::*;

  logic          en;
  logic          dec_valid, exe_valid, div_valid;
  dec_t          dec;
  div_t          exe, dv;
  logic          out_valid_q;
  logic [2:0]    rt_d, rt_q;
  logic [XW-1:0] rv_d, rv_q, pick;
  logic [1:0]    st_d, st_q;

  // advance everything whenever the output slot is free or being taken
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  tva_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .op_i    (operation_i),
    .ta_i    (type_a_i),
    .a_i     (value_a_i),
    .tb_i    (type_b_i),
    .b_i     (value_b_i),
    .valid_o (dec_valid),
    .dec_o   (dec)
  );

  tva_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dec_valid),
    .dec_i   (dec),
    .valid_o (exe_valid),
    .div_o   (exe)
  );

  tva_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (exe_valid),
    .div_i   (exe),
    .valid_o (div_valid),
    .div_o   (dv)
  );

  // restore quotient/remainder signs, pick the result, zero on error
  always_comb begin
    pick = (dv.meta.op == OP_DIV) ? dv.quo : dv.rem;
    if ((dv.meta.op == OP_DIV && dv.meta.neg_q) ||
        (dv.meta.op == OP_MOD && dv.meta.neg_r)) begin
      pick = '0 - pick;
    end
    pick = pick & wmask(dv.meta.narrow);
    rv_d = (dv.meta.op == OP_DIV || dv.meta.op == OP_MOD) ? pick : dv.meta.rv;
    rt_d = dv.meta.rt;
    st_d = dv.meta.st;
    if (dv.meta.st != ST_OK) begin
      rv_d = '0;
      rt_d = 3'(TY_I32);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= div_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_q <= rt_d;
      rv_q <= rv_d;
      st_q <= st_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_type_o  = rt_q;
  assign result_value_o = rv_q;
  assign status_o       = st_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operation words with random idle gaps and receiver stalls, predicts
// each tagged result from the type table, and checks results in order.
// ----------------------------------------------------------------------------

import tva_pkg::*;

// Result word as the ALU should deliver it.
typedef struct {
  logic [2:0]  rtype;
  logic [63:0] rval;
  logic [1:0]  rstat;
} alu_word_t;

class alu_scoreboard;
  alu_word_t pending[$];
  int        n_sent;
  int        n_checked;
  int        n_errors;
  int        status_seen[4];

  // Compute the tagged result of one operation word.
  function alu_word_t compute(logic [4:0] op, logic [2:0] ta, logic [63:0] a,
                              logic [2:0] tb, logic [63:0] b);
    alu_word_t   w;
    logic [63:0] m, x, y, q, r, ux, uy;
    logic        same_int, same_flt, lt, eq;
    int          s;
    w.rtype = 3'd0;
    w.rval  = 64'd0;
    w.rstat = ST_OK;
    m = is_narrow(ta) ? MASK32 : {64{1'b1}};
    same_int = (ta == tb) && (ta <= TY_UI64);
    same_flt = (ta == tb) && (ta == TY_F32 || ta == TY_F64);
    case (op)
      OP_ADD: begin
        if (same_int) begin
          w.rtype = ta; w.rval = (a + b) & m;
        end else if ((ta <= TY_UI32 && tb == TY_PTR) || (ta == TY_PTR && tb <= TY_UI32)) begin
          w.rtype = TY_PTR; w.rval = (a + b) & MASK32;
        end else w.rstat = same_flt ? ST_FLOAT : ST_BAD_TYPE;
      end
      OP_SUB: begin
        if (same_int) begin
          w.rtype = ta; w.rval = (a - b) & m;
        end else if (ta == TY_PTR && tb == TY_PTR) begin
          w.rtype = TY_I64; w.rval = (a & MASK32) - (b & MASK32);
        end else if (ta == TY_PTR && tb <= TY_UI32) begin
          w.rtype = TY_PTR; w.rval = (a - b) & MASK32;
        end else w.rstat = same_flt ? ST_FLOAT : ST_BAD_TYPE;
      end
      OP_MUL: begin
        if (same_int) begin
          w.rtype = ta; w.rval = (a * b) & m;
        end else w.rstat = same_flt ? ST_FLOAT : ST_BAD_TYPE;
      end
      OP_DIV, OP_MOD: begin
        if (same_int) begin
          x = a & m; y = b & m;
          if (y == 0) w.rstat = ST_DIV_ZERO;
          else begin
            if (ta == TY_I32 || ta == TY_I64) begin
              if (ta == TY_I32) begin
                x = {{32{x[31]}}, x[31:0]}; y = {{32{y[31]}}, y[31:0]};
              end
              // Divide magnitudes; quotient sign from both, remainder from dividend.
              ux = x[63] ? -x : x;
              uy = y[63] ? -y : y;
              q = ux / uy; r = ux % uy;
              if (x[63] != y[63]) q = -q;
              if (x[63]) r = -r;
            end else begin
              q = x / y; r = x % y;
            end
            w.rtype = ta;
            w.rval  = (op == OP_DIV ? q : r) & m;
          end
        end else w.rstat = same_flt ? ST_FLOAT : ST_BAD_TYPE;
      end
      OP_NOT: begin
        if (ta <= TY_UI64) begin
          w.rtype = ta; w.rval = ~a & m;
        end else w.rstat = ST_BAD_TYPE;
      end
      OP_AND, OP_OR, OP_XOR: begin
        if (same_int) begin
          w.rtype = ta;
          w.rval  = (op == OP_AND ? (a & b) : op == OP_OR ? (a | b) : (a ^ b)) & m;
        end else w.rstat = ST_BAD_TYPE;
      end
      OP_SHL, OP_SHR, OP_SAR: begin
        if (ta <= TY_UI64 && tb <= TY_UI64) begin
          s = int'(b[5:0]) & (is_narrow(ta) ? 31 : 63);
          x = a & m;
          w.rtype = ta;
          if (op == OP_SHL) w.rval = (x << s) & m;
          else if (op == OP_SHR || ta == TY_UI32) w.rval = x >> s;
          else if (ta == TY_I32) w.rval = ($signed({{32{x[31]}}, x[31:0]}) >>> s) & MASK32;
          else w.rval = $signed(x) >>> s;
        end else w.rstat = ST_BAD_TYPE;
      end
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
        if (ta != tb || ta == 3'd7) w.rstat = ST_BAD_TYPE;
        else if (op >= OP_LT && (ta == TY_F32 || ta == TY_F64)) w.rstat = ST_FLOAT;
        else begin
          x = a & m; y = b & m;
          eq = (x == y);
          if (ta == TY_I32) begin
            x = {{32{x[31]}}, x[31:0]}; y = {{32{y[31]}}, y[31:0]};
          end
          if (ta == TY_I32 || ta == TY_I64) begin
            x[63] = ~x[63]; y[63] = ~y[63];
          end
          lt = x < y;
          w.rtype = TY_UI32;
          case (op)
            OP_EQ:   w.rval = eq;
            OP_NE:   w.rval = !eq;
            OP_LT:   w.rval = lt;
            OP_LE:   w.rval = lt || eq;
            OP_GT:   w.rval = !lt && !eq;
            default: w.rval = !lt;
          endcase
        end
      end
      default: w.rstat = ST_BAD_TYPE;
    endcase
    if (w.rstat != ST_OK) begin
      w.rtype = 3'd0; w.rval = 64'd0;
    end
    return w;
  endfunction

  function void note_input(logic [4:0] op, logic [2:0] ta, logic [63:0] a,
                           logic [2:0] tb, logic [63:0] b);
    alu_word_t w;
    w = compute(op, ta, a, tb, b);
    pending.push_back(w);
    status_seen[w.rstat]++;
    n_sent++;
  endfunction

  function void check_result(logic [2:0] rt, logic [63:0] rv, logic [1:0] st);
    alu_word_t w;
    if (pending.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("ERROR: unexpected result type=%0d value=%h status=%0d",
                                   rt, rv, st);
      return;
    end
    w = pending.pop_front();
    n_checked++;
    if (rt !== w.rtype || rv !== w.rval || st !== w.rstat) begin
      n_errors++;
      if (n_errors <= 10)
        $display("ERROR: result %0d: exp type=%0d value=%h status=%0d, got type=%0d value=%h status=%0d",
                 n_checked - 1, w.rtype, w.rval, w.rstat, rt, rv, st);
    end
  endfunction
endclass

module testbench;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [4:0]  operation_i = '0;
  logic [2:0]  type_a_i = '0;
  logic [63:0] value_a_i = '0;
  logic [2:0]  type_b_i = '0;
  logic [63:0] value_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  result_type_o;
  logic [63:0] result_value_o;
  logic [1:0]  status_o;

  alu_scoreboard sb = new();
  bit  sending_done = 0;
  int  cycle_no = 0;

  typed_vm_integer_alu uut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_no <= cycle_no + 1;

  // Note each accepted input word and check each accepted result word,
  // both on the edge that completes the handshake.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_input(operation_i, type_a_i, value_a_i, type_b_i, value_b_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(result_type_o, result_value_o, status_o);
  end

  // Random 64-bit operand, biased toward the corner values that matter for
  // wraparound, sign handling and division overflow.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return {64{1'b1}};
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h0000_0000_8000_0000;
      4: return 64'h0000_0000_FFFF_FFFF;
      5: return 64'($urandom_range(0, 70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one word and hold it until accepted; idle first when asked.
  task automatic send_word(input logic [4:0] op, input logic [2:0] ta,
                           input logic [63:0] a, input logic [2:0] tb,
                           input logic [63:0] b, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    type_a_i    <= ta;
    value_a_i   <= a;
    type_b_i    <= tb;
    value_b_i   <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off to fill the pipeline, and a
  // stretch where results are always taken.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (cycle_no > 200 && cycle_no < 202) begin
        // Hold off long enough that the 68-deep pipe fills and backs up.
        out_ready_i <= 1'b0;
        for (hold = 0; hold < 200; hold++) @(posedge clk_i);
      end
      if (cycle_no > 450 && cycle_no < 650) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 99) >= 33);
    end
  end

  initial begin
    logic [4:0]  op;
    logic [2:0]  ta, tb;
    logic [63:0] a, b;
    int          i;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation on matching types, then the special cases.
    for (i = 0; i <= OP_GE; i++)
      send_word(5'(i), TY_I32, 64'hFFFF_FFFF_8000_0007, TY_I32, 64'h0000_0000_FFFF_FFFD, 1'b0);
    send_word(OP_DIV, TY_I64, 64'h8000_0000_0000_0000, TY_I64, {64{1'b1}}, 1'b0);
    send_word(OP_MOD, TY_I32, 64'h8000_0000, TY_I32, 64'hFFFF_FFFF, 1'b0);
    send_word(OP_DIV, TY_UI32, 64'h1234, TY_UI32, 64'hFFFF_FFFF_0000_0000, 1'b0);
    send_word(OP_SUB, TY_PTR, 64'h10, TY_PTR, 64'hFFFF_FFFF, 1'b0);
    send_word(OP_ADD, TY_F64, 64'd1, TY_F64, 64'd2, 1'b0);
    send_word(OP_EQ, TY_F32, 64'd5, TY_F32, 64'd5, 1'b0);
    send_word(OP_LT, 3'd7, 64'd1, 3'd7, 64'd2, 1'b0);
    send_word(5'd31, TY_I64, {64{1'b1}}, TY_I64, {64{1'b1}}, 1'b1);

    // Random: mostly well-typed pairs, some mixed or odd codes.
    for (i = 0; i < 400; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                        : 5'($urandom_range(0, 17));
      ta = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0, 1:    tb = 3'($urandom_range(0, 7));
        2:       tb = (ta == TY_PTR) ? 3'($urandom_range(0, 1)) : TY_PTR;
        default: tb = ta;
      endcase
      if (op == OP_DIV || op == OP_MOD) ta = (ta > TY_UI64 && $urandom_range(0, 3) != 0)
                                             ? 3'($urandom_range(0, 3)) : ta;
      a = pick_value();
      b = pick_value();
      // Stretch without idling on the input side.
      send_word(op, ta, a, tb, b, !(i >= 150 && i < 230));
    end
    in_valid_i <= 1'b0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Checked %0d result words: ok=%0d bad-type=%0d div-zero=%0d float=%0d.",
             sb.n_checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3]);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("Mismatches: %0d", sb.n_errors);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", sb.pending.size());
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/tva_pkg.sv
rtl/tva_decode.sv
rtl/tva_exec.sv
rtl/tva_div_stage.sv
rtl/tva_divider.sv
rtl/typed_vm_integer_alu.sv
dv/testbench.sv
